// File: src/ptps_pkg.sv
// package for the periodic task scheduler: item structs, command codes,
// controller/datapath interface structs; no dependencies
package ptps_pkg;

    localparam int FIELD_W    = 16;
    localparam int SLOT_W     = 4;
    localparam int CMD_W      = 2;
    localparam int TICK_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        POL_RM = 2'd0,
        POL_DM = 2'd1,
        POL_EDF = 2'd2
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY = 4'd0,
        CFG_ACTIVE = 4'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  task_slot;
        logic [FIELD_W-1:0] task_period;
        logic [FIELD_W-1:0] task_budget;
        logic [FIELD_W-1:0] task_deadline;
    } t_in_item;

    typedef struct packed {
        logic              run_valid;
        logic [SLOT_W-1:0] run_task;
        logic              job_finished;
        logic [TICK_W-1:0] tick_number;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic restart;
        logic emit_idle;
        logic tick_inc;
        logic scan_begin;
        logic issue;
        logic commit;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic n_zero;
        logic scan_last;
    } t_ctl_sts;

endpackage

// File: src/ptps_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ptps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ptps_ctrl.sv
// scheduler controller: accepts items and sequences the per-tick task walk
// depends on ptps_pkg
module ptps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_cmd,
    input  ptps_pkg::t_ctl_sts  i_sts,
    output ptps_pkg::t_ctl_cmd  o_ctl,
    output logic                o_busy
);

    ptps_pkg::t_state r_state;
    ptps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ptps_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        ptps_pkg::CMD_LOAD: begin
                            o_ctl.load      = 1'b1;
                            o_ctl.emit_idle = 1'b1;
                        end
                        ptps_pkg::CMD_TICK: begin
                            if (i_sts.n_zero) begin
                                o_ctl.emit_idle = 1'b1;
                                o_ctl.tick_inc  = 1'b1;
                            end else begin
                                o_ctl.scan_begin = 1'b1;
                                n_state          = ptps_pkg::ST_SCAN;
                            end
                        end
                        ptps_pkg::CMD_RESTART: begin
                            o_ctl.restart   = 1'b1;
                            o_ctl.emit_idle = 1'b1;
                        end
                        default: begin
                            o_ctl.emit_idle = 1'b1;
                        end
                    endcase
                end
            end
            ptps_pkg::ST_SCAN: begin
                o_ctl.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ptps_pkg::ST_DRAIN;
                end
            end
            ptps_pkg::ST_DRAIN: begin
                // last entry is processed in this cycle
                n_state = ptps_pkg::ST_COMMIT;
            end
            ptps_pkg::ST_COMMIT: begin
                o_ctl.commit = 1'b1;
                n_state      = ptps_pkg::ST_IDLE;
            end
            default: begin
                n_state = ptps_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ptps_pkg::ST_IDLE);

endmodule

// File: src/ptps_dpath.sv
// scheduler datapath: config registers, task tables, job state, selection
// depends on ptps_pkg and ptps_ram
module ptps_dpath #(
    parameter int MAX_TASKS  = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ptps_pkg::t_in_item                    i_item,
    input  logic                                  i_cfg_we,
    input  logic [ptps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ptps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  ptps_pkg::t_ctl_cmd                    i_ctl,
    output ptps_pkg::t_ctl_sts                    o_sts,
    output logic                                  o_strobe,
    output ptps_pkg::t_out_item                   o_result
);

    localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TW  = TIME_WIDTH;
    localparam int DW  = TIME_WIDTH + 2;
    localparam int TBW = 3 * TIME_WIDTH;
    localparam int JW  = 3 * TIME_WIDTH + 2;
    localparam logic [DW-1:0] TTD_MIN = {1'b1, {(DW-1){1'b0}}};

    logic [1:0]              r_policy;
    logic [4:0]              r_active;
    logic [31:0]             r_tick;
    logic [MAX_TASKS-1:0]    r_tab_vld;
    logic [MAX_TASKS-1:0]    r_job_vld;
    logic [IW-1:0]           r_rd_idx;
    logic                    r_pv;
    logic [IW-1:0]           r_pidx;
    logic                    r_tv_q;
    logic                    r_jv_q;
    logic                    r_best_vld;
    logic [IW-1:0]           r_best_idx;
    logic signed [DW-1:0]    r_best_key;
    logic [JW-1:0]           r_best_word;
    logic                    r_strobe;
    ptps_pkg::t_out_item     r_result;

    logic [6:0]              act7;
    logic [6:0]              n7;
    logic [IW-1:0]           last_idx;
    logic                    slot_ok;
    logic [IW-1:0]           slot_addr;
    logic [TBW-1:0]          tab_wdata;
    logic [TBW-1:0]          tab_rdata;
    logic [JW-1:0]           job_rdata;
    logic                    job_we;
    logic [IW-1:0]           job_waddr;
    logic [JW-1:0]           job_wdata;

    logic [TW-1:0]           per;
    logic [TW-1:0]           bud;
    logic [TW-1:0]           dl;
    logic [TW-1:0]           rem;
    logic [TW-1:0]           ttr;
    logic [DW-1:0]           ttd;
    logic [TW-1:0]           rem_n;
    logic [TW-1:0]           ttr_n;
    logic [DW-1:0]           ttd_n;
    logic [DW-1:0]           ttd_w;
    logic signed [DW-1:0]    key;
    logic                    better;
    logic [JW-1:0]           proc_word;
    logic [TW-1:0]           c_rem;
    logic [JW-1:0]           commit_word;

    // active count limited to the table depth
    always_comb begin
        act7 = 7'(r_active);
        if (act7 > 7'(MAX_TASKS)) begin
            n7 = 7'(MAX_TASKS);
        end else begin
            n7 = act7;
        end
        last_idx = IW'(n7 - 7'd1);
    end

    assign o_sts.n_zero    = (n7 == 7'd0);
    assign o_sts.scan_last = (r_rd_idx == last_idx);

    assign slot_ok   = (7'(i_item.task_slot) < 7'(MAX_TASKS));
    assign slot_addr = IW'(i_item.task_slot);
    assign tab_wdata = {TW'(i_item.task_period), TW'(i_item.task_budget),
                        TW'(i_item.task_deadline)};

    ptps_ram #(
        .WIDTH(TBW),
        .DEPTH(MAX_TASKS)
    ) u_tab_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.load && slot_ok),
        .i_waddr(slot_addr),
        .i_wdata(tab_wdata),
        .i_raddr(r_rd_idx),
        .o_rdata(tab_rdata)
    );

    ptps_ram #(
        .WIDTH(JW),
        .DEPTH(MAX_TASKS)
    ) u_job_ram (
        .i_clk  (i_clk),
        .i_we   (job_we),
        .i_waddr(job_waddr),
        .i_wdata(job_wdata),
        .i_raddr(r_rd_idx),
        .o_rdata(job_rdata)
    );

    // release, key and deadline countdown for the entry read last cycle
    always_comb begin
        per = r_tv_q ? tab_rdata[TBW-1 -: TW] : '0;
        bud = r_tv_q ? tab_rdata[2*TW-1 -: TW] : '0;
        dl  = r_tv_q ? tab_rdata[TW-1:0] : '0;
        rem = r_jv_q ? job_rdata[JW-1 -: TW] : '0;
        ttr = r_jv_q ? job_rdata[2*TW+1 -: TW] : '0;
        ttd = r_jv_q ? job_rdata[DW-1:0] : '0;

        if (ttr == '0) begin
            rem_n = bud;
            ttd_n = {2'b00, dl};
            ttr_n = (per == '0) ? '0 : per - TW'(1);
        end else begin
            rem_n = rem;
            ttd_n = ttd;
            ttr_n = ttr - TW'(1);
        end

        unique case (r_policy)
            ptps_pkg::POL_RM: key = $signed({2'b00, per});
            ptps_pkg::POL_DM: key = $signed({2'b00, dl});
            default:          key = $signed(ttd_n);
        endcase

        better = (rem_n != '0) && (!r_best_vld || (key < r_best_key));
        ttd_w  = (ttd_n == TTD_MIN) ? ttd_n : ttd_n - DW'(1);
        proc_word = {rem_n, ttr_n, ttd_w};

        c_rem       = r_best_word[JW-1 -: TW] - TW'(1);
        commit_word = {c_rem, r_best_word[2*TW+1:0]};

        if (i_ctl.commit) begin
            job_we    = r_best_vld;
            job_waddr = r_best_idx;
            job_wdata = commit_word;
        end else begin
            job_we    = r_pv;
            job_waddr = r_pidx;
            job_wdata = proc_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= ptps_pkg::POL_RM;
            r_active   <= 5'd1;
            r_tick     <= '0;
            r_tab_vld  <= '0;
            r_job_vld  <= '0;
            r_rd_idx   <= '0;
            r_pv       <= 1'b0;
            r_best_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == ptps_pkg::CFG_POLICY) begin
                    r_policy <= i_cfg_data[1:0];
                end else if (i_cfg_index == ptps_pkg::CFG_ACTIVE) begin
                    r_active <= i_cfg_data;
                end
            end

            if (i_ctl.load && slot_ok) begin
                r_tab_vld[slot_addr] <= 1'b1;
            end

            if (i_ctl.restart) begin
                r_job_vld <= '0;
                r_tick    <= '0;
            end else if (i_ctl.tick_inc || i_ctl.commit) begin
                r_tick <= r_tick + 32'd1;
            end

            if (i_ctl.scan_begin) begin
                r_rd_idx   <= '0;
                r_best_vld <= 1'b0;
            end else if (i_ctl.issue) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end

            r_pv <= i_ctl.issue;
            if (r_pv) begin
                r_job_vld[r_pidx] <= 1'b1;
                if (better) begin
                    r_best_vld <= 1'b1;
                end
            end

            r_strobe <= i_ctl.emit_idle || i_ctl.commit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_pidx <= r_rd_idx;
            r_tv_q <= r_tab_vld[r_rd_idx];
            r_jv_q <= r_job_vld[r_rd_idx];
        end
        if (r_pv && better) begin
            r_best_idx  <= r_pidx;
            r_best_key  <= key;
            r_best_word <= proc_word;
        end
        if (i_ctl.commit) begin
            r_result.run_valid    <= r_best_vld;
            r_result.run_task     <= r_best_vld ? ptps_pkg::SLOT_W'(r_best_idx) : '0;
            r_result.job_finished <= r_best_vld && (c_rem == '0);
            r_result.tick_number  <= r_tick;
        end else if (i_ctl.emit_idle) begin
            r_result.run_valid    <= 1'b0;
            r_result.run_task     <= '0;
            r_result.job_finished <= 1'b0;
            r_result.tick_number  <= i_ctl.restart ? '0 : r_tick;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: src/periodic_task_priority_scheduler.sv
// top level of the periodic task scheduler
// depends on ptps_pkg, ptps_ctrl, ptps_dpath (and ptps_ram below it)
//
// Load, restart and unused command items take no walk: busy stays low and
// the result strobe follows on the next cycle. A tick item walks the active
// task entries one per cycle through the job state ram, then passes the
// drain and commit states, where the selection is written back, before its
// result strobe, walking n = min(active_tasks, MAX_TASKS) entries; a tick
// with no active tasks is idle, with no walk. Results come out on o_strobe
// for exactly one cycle and cannot be held off. Configuration writes are
// always accepted and should only be issued while busy is low.
module periodic_task_priority_scheduler #(
    parameter int MAX_TASKS  = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ptps_pkg::t_in_item                  i_item,
    output logic                                o_strobe,
    output ptps_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ptps_pkg::t_ctl_cmd ctl;
    ptps_pkg::t_ctl_sts sts;
    logic               busy_int;

    assign busy        = busy_int;
    assign o_cfg_ready = 1'b1;

    ptps_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_cmd  (i_item.cmd),
        .i_sts  (sts),
        .o_ctl  (ctl),
        .o_busy (busy_int)
    );

    ptps_dpath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_WIDTH(TIME_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// File: verif/tb_periodic_task_priority_scheduler.sv
// testbench for periodic_task_priority_scheduler: directed table, then random
// segments under changing policy and task counts, checked by a predictor, but
// typed table rows against fixed results; depends on ptps_pkg, scheduler rtl
`timescale 1ns / 100ps

module tb_periodic_task_priority_scheduler;

    localparam int NUM_SLOTS   = 16;
    localparam int TTD_FLOOR   = -(1 << 17);
    localparam int PLAN_ROWS   = 28;
    localparam int SEGMENTS    = 8;
    localparam int SEG_ITEMS   = 100;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [ptps_pkg::CMD_W-1:0]     CMD_UNUSED    = 2'd3;
    localparam logic [1:0]                     POL_EDF_ALIAS = 2'd3;
    localparam logic [ptps_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 4'hF;

    typedef struct {
        bit                  is_cfg;
        logic [1:0]          pol;
        logic [4:0]          act;
        ptps_pkg::t_in_item  it;
        bit                  typed;
        ptps_pkg::t_out_item want;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    ptps_pkg::t_in_item i_item;
    logic o_strobe;
    ptps_pkg::t_out_item o_result;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [ptps_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ptps_pkg::CFG_DATA_W-1:0] i_cfg_data;

    periodic_task_priority_scheduler #(
        .MAX_TASKS (NUM_SLOTS),
        .TIME_WIDTH(16)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // scheduler state as the block should hold it
    logic [15:0] period_tab [NUM_SLOTS];
    logic [15:0] budget_tab [NUM_SLOTS];
    logic [15:0] dline_tab [NUM_SLOTS];
    logic [15:0] budget_left [NUM_SLOTS];
    logic [15:0] release_cnt [NUM_SLOTS];
    int          dline_cnt [NUM_SLOTS];
    logic [31:0] tick_cnt;
    logic [1:0]  policy_reg;
    logic [4:0]  active_reg;

    ptps_pkg::t_out_item expected_runs [$];
    t_plan_row plan [PLAN_ROWS];
    int mismatches;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void clear_jobs();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            budget_left[i] = '0;
            release_cnt[i] = '0;
            dline_cnt[i] = 0;
        end
        tick_cnt = '0;
    endfunction

    // advances the scheduler state by one item and returns the run it reports
    function automatic ptps_pkg::t_out_item schedule_item(ptps_pkg::t_in_item it);
        ptps_pkg::t_out_item r;
        int n;
        int best;
        int best_key;
        int key;
        logic [15:0] per;
        r = '0;
        case (it.cmd)
            ptps_pkg::CMD_LOAD: begin
                period_tab[it.task_slot] = it.task_period;
                budget_tab[it.task_slot] = it.task_budget;
                dline_tab[it.task_slot] = it.task_deadline;
            end
            ptps_pkg::CMD_RESTART: clear_jobs();
            default: ;
        endcase
        r.tick_number = tick_cnt;
        if (it.cmd != ptps_pkg::CMD_TICK) return r;

        n = (active_reg > NUM_SLOTS) ? NUM_SLOTS : int'(active_reg);
        for (int i = 0; i < n; i++) begin
            if (release_cnt[i] == 0) begin
                per = (period_tab[i] == 0) ? 16'd1 : period_tab[i];
                budget_left[i] = budget_tab[i];
                dline_cnt[i] = int'({16'd0, dline_tab[i]});
                release_cnt[i] = per - 16'd1;
            end else begin
                release_cnt[i] = release_cnt[i] - 16'd1;
            end
        end

        best = -1;
        best_key = 0;
        for (int i = 0; i < n; i++) begin
            if (budget_left[i] != 0) begin
                if (policy_reg == ptps_pkg::POL_RM) key = int'({16'd0, period_tab[i]});
                else if (policy_reg == ptps_pkg::POL_DM) key = int'({16'd0, dline_tab[i]});
                else key = dline_cnt[i];
                if (best < 0 || key < best_key) begin
                    best = i;
                    best_key = key;
                end
            end
        end

        if (best >= 0) begin
            budget_left[best] = budget_left[best] - 16'd1;
            r.run_valid = 1'b1;
            r.run_task = best[ptps_pkg::SLOT_W-1:0];
            r.job_finished = (budget_left[best] == 0);
        end

        for (int i = 0; i < n; i++) begin
            if (dline_cnt[i] > TTD_FLOOR) dline_cnt[i] = dline_cnt[i] - 1;
        end
        tick_cnt = tick_cnt + 32'd1;
        return r;
    endfunction

    function automatic t_plan_row step_row(logic [1:0] cmd, logic [3:0] slot,
                                           logic [15:0] per, logic [15:0] bud,
                                           logic [15:0] dl, bit typed,
                                           logic [31:0] idle_tick);
        t_plan_row r;
        r = '{default: '0};
        r.it.cmd = cmd;
        r.it.task_slot = slot;
        r.it.task_period = per;
        r.it.task_budget = bud;
        r.it.task_deadline = dl;
        r.typed = typed;
        r.want.tick_number = idle_tick;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [1:0] pol, logic [4:0] act);
        t_plan_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.pol = pol;
        r.act = act;
        return r;
    endfunction

    // mostly small, well-formed task entries so that jobs contend; now and
    // then a full-range entry
    function automatic ptps_pkg::t_in_item load_item(logic [3:0] slot);
        ptps_pkg::t_in_item it;
        it.cmd = ptps_pkg::CMD_LOAD;
        it.task_slot = slot;
        if ($urandom_range(9) == 0) begin
            it.task_period = 16'($urandom);
            it.task_budget = 16'($urandom);
            it.task_deadline = 16'($urandom);
        end else begin
            it.task_period = 16'($urandom_range(1, 24));
            it.task_budget = 16'($urandom_range(0, 6));
            it.task_deadline = 16'($urandom_range(1, 24));
        end
        return it;
    endfunction

    function automatic ptps_pkg::t_in_item random_item();
        ptps_pkg::t_in_item it;
        int roll;
        roll = $urandom_range(99);
        it.task_slot = 4'($urandom);
        it.task_period = 16'($urandom);
        it.task_budget = 16'($urandom);
        it.task_deadline = 16'($urandom);
        if (roll < 2) it.cmd = CMD_UNUSED;
        else if (roll < 5) it.cmd = ptps_pkg::CMD_RESTART;
        else if (roll < 20) it = load_item(4'($urandom));
        else it.cmd = ptps_pkg::CMD_TICK;
        return it;
    endfunction

    // called right after a rising edge; leaves start high once accepted
    task automatic send_item(ptps_pkg::t_in_item it, bit typed,
                             ptps_pkg::t_out_item want);
        ptps_pkg::t_out_item pred;
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pred = schedule_item(it);
        expected_runs.push_back(typed ? want : pred);
    endtask

    task automatic offer_item(ptps_pkg::t_in_item it, int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        send_item(it, 1'b0, '0);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_runs.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [1:0] pol, logic [4:0] act);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ptps_pkg::CFG_POLICY;
        i_cfg_data <= {3'b000, pol};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= ptps_pkg::CFG_ACTIVE;
        i_cfg_data <= act;
        do @(posedge i_clk); while (!o_cfg_ready);
        // unmapped index, must leave both registers alone
        i_cfg_index <= CFG_SPARE;
        i_cfg_data <= 5'($urandom_range(31));
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        policy_reg = pol;
        active_reg = act;
    endtask

    always @(posedge i_clk) begin
        ptps_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid=%0d task=%0d done=%0d tick=%0d",
                             o_result.run_valid, o_result.run_task,
                             o_result.job_finished, o_result.tick_number);
            end else begin
                want = expected_runs.pop_front();
                if (o_result.run_valid !== want.run_valid
                    || o_result.run_task !== want.run_task
                    || o_result.job_finished !== want.job_finished
                    || o_result.tick_number !== want.tick_number) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want valid=%0d task=%0d done=%0d tick=%0d, %s",
                                 want.run_valid, want.run_task, want.job_finished,
                                 want.tick_number,
                                 $sformatf("got valid=%0d task=%0d done=%0d tick=%0d",
                                           o_result.run_valid, o_result.run_task,
                                           o_result.job_finished,
                                           o_result.tick_number));
                end
            end
        end
    end

    initial begin
        int idle_pct;
        int n;
        logic [4:0] act;
        logic [4:0] act_list [SEGMENTS];

        mismatches = 0;
        cycles = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ptps_pkg::CFG_POLICY;
        i_cfg_data <= '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            period_tab[i] = '0;
            budget_tab[i] = '0;
            dline_tab[i] = '0;
        end
        clear_jobs();
        policy_reg = ptps_pkg::POL_RM;
        active_reg = 5'd1;

        plan = '{
            // one active entry, all zero: released with no budget, so idle
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1, 32'd0),
            step_row(CMD_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 32'd1),
            step_row(ptps_pkg::CMD_LOAD, 4'd0, 16'd4, 16'd2, 16'd3, 1, 32'd1),
            step_row(ptps_pkg::CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 32'd1),
            // period zero behaves as one
            step_row(ptps_pkg::CMD_LOAD, 4'd1, 16'd0, 16'd1, 16'd1, 1, 32'd1),
            // budget above period: re-released while unfinished, goes overdue
            step_row(ptps_pkg::CMD_LOAD, 4'd2, 16'd2, 16'd5, 16'd1, 1, 32'd1),
            // budget zero never runs
            step_row(ptps_pkg::CMD_LOAD, 4'd3, 16'd1, 16'd0, 16'hFFFF, 1, 32'd1),
            cfg_row(ptps_pkg::POL_RM, 5'd16),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            cfg_row(ptps_pkg::POL_DM, 5'd16),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            cfg_row(POL_EDF_ALIAS, 5'd16),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_RESTART, 4'd5, 16'h1234, 16'h5678, 16'h9ABC, 1, 32'd0),
            // no active entries
            cfg_row(ptps_pkg::POL_EDF, 5'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1, 32'd0),
            // count above the table size is clamped
            cfg_row(ptps_pkg::POL_EDF, 5'd31),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            step_row(ptps_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 0, 32'd0),
            cfg_row(ptps_pkg::POL_RM, 5'd1)
        };

        act_list = '{5'd16, 5'd1, 5'($urandom_range(2, 15)), 5'd31,
                     5'd16, 5'($urandom_range(0, 16)), 5'd8, 5'd16};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                settle();
                write_regs(plan[r].pol, plan[r].act);
            end else begin
                send_item(plan[r].it, plan[r].typed, plan[r].want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct = (seg < 3) ? 6 : (seg < 6) ? 62 : 0;
            act = act_list[seg];
            settle();
            write_regs(2'(seg % 4), act);
            n = (act > NUM_SLOTS) ? NUM_SLOTS : int'(act);
            for (int s = 0; s < n; s++) offer_item(load_item(4'(s)), idle_pct);
            for (int k = n; k < SEG_ITEMS; k++) begin
                // sender holds off until the block has answered everything
                if (seg == 4 && k == SEG_ITEMS / 2) settle();
                offer_item(random_item(), idle_pct);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_runs.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
